// ===== hdl/pce_pkg.sv =====
// Package for the parametric curve evaluator.
// Holds the sequencer state type, request, curve kind and register codes, the sine
// polynomial constants and the fixed-point helper functions. No dependencies.
package pce_pkg;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE,
        ST_F_C0, ST_F_RDC, ST_F_MC, ST_F_AC, ST_F_AS, ST_F_SAT,
        ST_P_LD, ST_P_MUL, ST_P_ADD,
        ST_E_RA, ST_E_RB, ST_E_P, ST_E_Q, ST_E_PP, ST_E_QQ, ST_E_SUM,
        ST_E_SQRT, ST_E_SQD, ST_E_DIV, ST_E_R, ST_E_C0, ST_E_C1, ST_E_T,
        ST_E_DG1, ST_E_DG2,
        ST_T_SQ, ST_T_Z2, ST_T_MA, ST_T_MB, ST_T_MZ, ST_T_MF,
        ST_DONE
    } pce_state_t;

    // Request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // Curve kinds
    localparam logic [1:0] KIND_FOURIER = 2'd0;
    localparam logic [1:0] KIND_POLY    = 2'd1;
    localparam logic [1:0] KIND_ELLIPSE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_CURVE_KIND = 2'd0;
    localparam logic [1:0] REG_TERM_COUNT = 2'd1;

    // Sine polynomial constants, Q30
    localparam logic [31:0] K1 = 32'd1686629713;
    localparam logic [31:0] K3 = 32'd693598669;
    localparam logic [31:0] K5 = 32'd85569306;
    localparam logic [31:0] K7 = 32'd5026995;
    localparam logic [31:0] K9 = 32'd172271;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Constant used by Horner step of the sine polynomial
    function automatic logic [31:0] sine_k(input logic [1:0] step);
        logic [31:0] k;
        case (step)
            2'd0:    k = K7;
            2'd1:    k = K5;
            2'd2:    k = K3;
            default: k = K1;
        endcase
        return k;
    endfunction

    // Fold a phase into the first quadrant, Q30
    function automatic logic [30:0] trig_z(input logic [31:0] ph);
        logic [30:0] f;
        f = {1'b0, ph[29:0]};
        if (ph[30]) begin
            f = 31'(ONE_Q30) - f;
        end
        return f;
    endfunction

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Round half up and shift a product right by 30
    function automatic logic signed [35:0] round30(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd536870912;
        return $signed(t[65:30]);
    endfunction

    // Round half up and shift a product right by 16
    function automatic logic signed [49:0] round16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd32768;
        return $signed(t[65:16]);
    endfunction

    // Magnitude of a signed word, one bit wider
    function automatic logic signed [32:0] abs33(input logic signed [32:0] v);
        return (v < 0) ? -v : v;
    endfunction

endpackage

// ===== hdl/parametric_curve_evaluator_core.sv =====
// Parametric curve evaluator top level: coefficient memory, sequencer and
// shared datapath (multiplier, square root, divider). Depends on pce_pkg.
//
// Write items (req_type 0) store one coefficient in the coefficient memory;
// an index past 2*MAX_TERMS is dropped. Evaluate items (req_type 1) give
// one point (s,t) in signed Q15.16 for the curve kind set in curve_kind,
// with degenerate raised when an ellipse radius denominator is zero. One
// item is worked on at a time; a finished point waits in the output
// register while the next item is taken. The datapath has the single
// shared 33x33 multiplier, the sine polynomial, a square root resolving one
// root bit per cycle and a divider resolving one quotient bit per cycle.
// Coefficients read before they are written return undefined data.
module parametric_curve_evaluator_core #(
    parameter int MAX_TERMS  = 16,
    parameter int PHASE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_wdata,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [5:0]         s_coef_index,
    input  logic signed [31:0] s_coef_value,
    input  logic [15:0]        s_param_x,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_s_coord,
    output logic signed [31:0] m_t_coord,
    output logic               m_degenerate
);
    import pce_pkg::*;

    localparam int DEPTH = 2 * MAX_TERMS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_TERMS + 1);
    localparam logic [31:0] PH_MASK = 32'hFFFF_FFFF << (32 - PHASE_BITS);

    // configuration registers
    logic [1:0] kind_reg;
    logic [4:0] tc_reg;

    // sequencer
    pce_state_t state_reg, state_next, ret_reg, trig_ret;
    logic       trig_go;
    logic [15:0] trig_ph;
    logic       mul_en;
    logic signed [32:0] mul_a, mul_b;
    logic [AW-1:0] rd_addr;

    // memory
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    // datapath
    logic signed [65:0] mul_reg;
    logic [15:0]        x_reg, ph_reg;
    logic [NW-1:0]      i_reg, n_eff;
    logic signed [39:0] acc_reg;
    logic signed [31:0] pacc_reg;
    logic [30:0]        z_reg, z2_reg;
    logic [31:0]        tacc_reg, tph_reg;
    logic [1:0]         step_reg;
    logic               tneg_reg, tsel_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic signed [31:0] a_reg, b_reg, r_reg, c0_reg, c1_reg;
    logic [31:0]        pm_reg, qm_reg, d_reg;
    logic [63:0]        sq_reg, sqv_reg, sres_reg, sbit_reg, num_reg;
    logic [31:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic signed [31:0] res_s_reg, res_t_reg;
    logic               res_deg_reg;
    logic               m_valid_reg;
    logic signed [31:0] out_s_reg, out_t_reg;
    logic               out_deg_reg;

    // datapath helpers
    logic               accept;
    logic [31:0]        trig_ph32, trig_cph;
    logic [31:0]        tmag;
    logic signed [31:0] tval;
    logic [63:0]        sq_try;
    logic [32:0]        rem_sh;
    logic [32:0]        rm;
    logic signed [31:0] pval;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign n_eff   = (32'(tc_reg) > 32'(MAX_TERMS)) ? NW'(MAX_TERMS) : NW'(tc_reg);

    assign m_valid      = m_valid_reg;
    assign m_s_coord    = out_s_reg;
    assign m_t_coord    = out_t_reg;
    assign m_degenerate = out_deg_reg;

    // phase setup for the sine unit
    assign trig_ph32 = {trig_ph, 16'h0000} & PH_MASK;
    assign trig_cph  = trig_ph32 + ONE_Q30;

    // sine result: cap at one and apply quadrant sign
    assign tmag = (mul_reg[61:30] > ONE_Q30) ? ONE_Q30 : mul_reg[61:30];
    assign tval = tneg_reg ? -$signed(tmag) : $signed(tmag);

    // square root trial and divider shift
    assign sq_try = sres_reg + sbit_reg;
    assign rem_sh = {rem_reg, num_reg[63]};

    // radius magnitude clamp at 2^31
    assign rm = (num_reg > 64'h8000_0000) ? 33'h0_8000_0000 : num_reg[32:0];

    // Horner step value
    assign pval = sat32(64'(round16(mul_reg)) + 64'(rd_data_reg));

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_FOURIER;
            tc_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CURVE_KIND: kind_reg <= cfg_wdata[1:0];
                REG_TERM_COUNT: tc_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Coefficient memory: writes only while idle, so reads never overlap them
    always_ff @(posedge aclk) begin
        if (accept && s_req_type == REQ_WRITE && 32'(s_coef_index) < 32'(DEPTH)) begin
            mem[AW'(s_coef_index)] <= s_coef_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Shared multiplier with registered product
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            mul_reg <= mul_a * mul_b;
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, memory address and multiplier operands
    always_comb begin
        state_next = state_reg;
        rd_addr    = '0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        trig_go    = 1'b0;
        trig_ph    = x_reg;
        trig_ret   = ST_F_RDC;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_req_type == REQ_EVAL) begin
                    unique case (kind_reg)
                        KIND_FOURIER: state_next = ST_F_C0;
                        KIND_POLY: begin
                            rd_addr    = AW'(n_eff);
                            state_next = ST_P_LD;
                        end
                        KIND_ELLIPSE: begin
                            rd_addr    = AW'(2);
                            state_next = ST_E_RA;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            // Fourier series
            ST_F_C0: begin
                if (n_eff == '0) begin
                    state_next = ST_F_SAT;
                end else begin
                    trig_go    = 1'b1;
                    trig_ph    = x_reg;
                    trig_ret   = ST_F_RDC;
                    state_next = ST_T_SQ;
                end
            end
            ST_F_RDC: begin
                rd_addr    = AW'(2 * 32'(i_reg) - 1);
                state_next = ST_F_MC;
            end
            ST_F_MC: begin
                mul_en     = 1'b1;
                mul_a      = 33'(rd_data_reg);
                mul_b      = 33'(cos_reg);
                rd_addr    = AW'(2 * 32'(i_reg));
                state_next = ST_F_AC;
            end
            ST_F_AC: begin
                mul_en     = 1'b1;
                mul_a      = 33'(rd_data_reg);
                mul_b      = 33'(sin_reg);
                state_next = ST_F_AS;
            end
            ST_F_AS: begin
                if (i_reg == n_eff) begin
                    state_next = ST_F_SAT;
                end else begin
                    trig_go    = 1'b1;
                    trig_ph    = ph_reg + x_reg;
                    trig_ret   = ST_F_RDC;
                    state_next = ST_T_SQ;
                end
            end
            ST_F_SAT: state_next = ST_DONE;
            // Polynomial
            ST_P_LD: state_next = (n_eff == '0) ? ST_DONE : ST_P_MUL;
            ST_P_MUL: begin
                mul_en     = 1'b1;
                mul_a      = 33'(pacc_reg);
                mul_b      = $signed({17'b0, x_reg});
                rd_addr    = AW'(32'(i_reg) - 1);
                state_next = ST_P_ADD;
            end
            ST_P_ADD: state_next = (i_reg == NW'(1)) ? ST_DONE : ST_P_MUL;
            // Ellipse
            ST_E_RA: begin
                rd_addr    = AW'(3);
                state_next = ST_E_RB;
            end
            ST_E_RB: begin
                trig_go    = 1'b1;
                trig_ph    = x_reg;
                trig_ret   = ST_E_P;
                state_next = ST_T_SQ;
            end
            ST_E_P: begin
                mul_en     = 1'b1;
                mul_a      = 33'(b_reg);
                mul_b      = 33'(cos_reg);
                state_next = ST_E_Q;
            end
            ST_E_Q: begin
                mul_en     = 1'b1;
                mul_a      = 33'(a_reg);
                mul_b      = 33'(sin_reg);
                state_next = ST_E_PP;
            end
            ST_E_PP: begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, pm_reg});
                mul_b      = $signed({1'b0, pm_reg});
                state_next = ST_E_QQ;
            end
            ST_E_QQ: begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, qm_reg});
                mul_b      = $signed({1'b0, qm_reg});
                state_next = ST_E_SUM;
            end
            ST_E_SUM: begin
                mul_en     = 1'b1;
                mul_a      = abs33(33'(a_reg));
                mul_b      = abs33(33'(b_reg));
                state_next = ST_E_SQRT;
            end
            ST_E_SQRT: begin
                if (sbit_reg == 64'd1) begin
                    state_next = ST_E_SQD;
                end
            end
            ST_E_SQD: begin
                if (sres_reg == '0) begin
                    rd_addr    = '0;
                    state_next = ST_E_DG1;
                end else begin
                    state_next = ST_E_DIV;
                end
            end
            ST_E_DIV: begin
                if (cnt_reg == 6'd63) begin
                    state_next = ST_E_R;
                end
            end
            ST_E_R: begin
                rd_addr    = '0;
                state_next = ST_E_C0;
            end
            ST_E_C0: begin
                mul_en     = 1'b1;
                mul_a      = 33'(r_reg);
                mul_b      = 33'(cos_reg);
                rd_addr    = AW'(1);
                state_next = ST_E_C1;
            end
            ST_E_C1: begin
                mul_en     = 1'b1;
                mul_a      = 33'(r_reg);
                mul_b      = 33'(sin_reg);
                state_next = ST_E_T;
            end
            ST_E_T: state_next = ST_DONE;
            ST_E_DG1: begin
                rd_addr    = AW'(1);
                state_next = ST_E_DG2;
            end
            ST_E_DG2: state_next = ST_DONE;
            // Sine unit: cosine first, then sine
            ST_T_SQ: begin
                mul_en     = 1'b1;
                mul_a      = $signed({2'b0, z_reg});
                mul_b      = $signed({2'b0, z_reg});
                state_next = ST_T_Z2;
            end
            ST_T_Z2: state_next = ST_T_MA;
            ST_T_MA: begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, tacc_reg});
                mul_b      = $signed({2'b0, z2_reg});
                state_next = ST_T_MB;
            end
            ST_T_MB: state_next = (step_reg == 2'd3) ? ST_T_MZ : ST_T_MA;
            ST_T_MZ: begin
                mul_en     = 1'b1;
                mul_a      = $signed({1'b0, tacc_reg});
                mul_b      = $signed({2'b0, z_reg});
                state_next = ST_T_MF;
            end
            ST_T_MF: state_next = tsel_reg ? ret_reg : ST_T_SQ;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        // start a cosine/sine pair
        if (trig_go) begin
            tph_reg  <= trig_ph32;
            z_reg    <= trig_z(trig_cph);
            tneg_reg <= trig_cph[31];
            tsel_reg <= 1'b0;
            ret_reg  <= trig_ret;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    x_reg       <= s_param_x;
                    res_s_reg   <= '0;
                    res_t_reg   <= (kind_reg == KIND_FOURIER || kind_reg == KIND_POLY)
                                   ? $signed({16'b0, s_param_x}) : '0;
                    res_deg_reg <= 1'b0;
                end
            end
            ST_F_C0: begin
                acc_reg <= 40'(rd_data_reg);
                i_reg   <= NW'(1);
                ph_reg  <= x_reg;
            end
            ST_F_AC: acc_reg <= acc_reg + 40'(round30(mul_reg));
            ST_F_AS: begin
                acc_reg <= acc_reg - 40'(round30(mul_reg));
                if (i_reg != n_eff) begin
                    i_reg  <= i_reg + NW'(1);
                    ph_reg <= ph_reg + x_reg;
                end
            end
            ST_F_SAT: res_s_reg <= sat32(64'(acc_reg));
            ST_P_LD: begin
                pacc_reg  <= rd_data_reg;
                res_s_reg <= rd_data_reg;
                i_reg     <= n_eff;
            end
            ST_P_ADD: begin
                pacc_reg  <= pval;
                res_s_reg <= pval;
                i_reg     <= i_reg - NW'(1);
            end
            ST_E_RA: a_reg <= rd_data_reg;
            ST_E_RB: b_reg <= rd_data_reg;
            ST_E_Q:  pm_reg <= 32'(abs33(33'(round30(mul_reg))));
            ST_E_PP: qm_reg <= 32'(abs33(33'(round30(mul_reg))));
            ST_E_QQ: sq_reg <= mul_reg[63:0];
            ST_E_SUM: begin
                sqv_reg  <= sq_reg + mul_reg[63:0];
                sres_reg <= '0;
                sbit_reg <= 64'd1 << 62;
            end
            ST_E_SQRT: begin
                if (sqv_reg >= sq_try) begin
                    sqv_reg  <= sqv_reg - sq_try;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            ST_E_SQD: begin
                d_reg   <= sres_reg[31:0];
                num_reg <= mul_reg[63:0] + (sres_reg >> 1);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_E_DIV: begin
                if (rem_sh >= {1'b0, d_reg}) begin
                    rem_reg <= 32'(rem_sh - {1'b0, d_reg});
                    num_reg <= {num_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[31:0];
                    num_reg <= {num_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_E_R: begin
                if (a_reg[31] != b_reg[31]) begin
                    r_reg <= 32'(-$signed(rm));
                end else begin
                    r_reg <= rm[31] ? 32'sh7FFF_FFFF : $signed(rm[31:0]);
                end
            end
            ST_E_C0: c0_reg <= rd_data_reg;
            ST_E_C1: begin
                c1_reg    <= rd_data_reg;
                res_s_reg <= sat32(64'(c0_reg) + 64'(round30(mul_reg)));
            end
            ST_E_T: res_t_reg <= sat32(64'(c1_reg) + 64'(round30(mul_reg)));
            ST_E_DG1: res_s_reg <= rd_data_reg;
            ST_E_DG2: begin
                res_t_reg   <= rd_data_reg;
                res_deg_reg <= 1'b1;
            end
            ST_T_Z2: begin
                z2_reg   <= mul_reg[60:30];
                tacc_reg <= K9;
                step_reg <= '0;
            end
            ST_T_MB: begin
                tacc_reg <= sine_k(step_reg) - mul_reg[61:30];
                step_reg <= step_reg + 2'd1;
            end
            ST_T_MF: begin
                if (!tsel_reg) begin
                    cos_reg  <= tval;
                    tsel_reg <= 1'b1;
                    z_reg    <= trig_z(tph_reg);
                    tneg_reg <= tph_reg[31];
                end else begin
                    sin_reg <= tval;
                end
            end
            default: ;
        endcase
    end

    // Output register: load a finished point, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            out_s_reg   <= res_s_reg;
            out_t_reg   <= res_t_reg;
            out_deg_reg <= res_deg_reg;
        end
    end

endmodule
